// ===== sv/lpr_pkg.sv =====
// shared types and constants of the lru page replacement block
package lpr_pkg;

  localparam int PAGE_BITS      = 16;
  localparam int RANK_BITS      = 4;
  localparam int FRAME_OUT_BITS = 4;
  localparam int FAULT_BITS     = 32;
  localparam int ACTIVE_BITS    = 5;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int ADDR_BITS_DEF  = 16;

  localparam logic [RANK_BITS-1:0]   RANK_MAX          = 4'd15;
  localparam logic [PAGE_BITS-1:0]   PAGE_BYTES_RST    = 16'd100;
  localparam logic [ACTIVE_BITS-1:0] ACTIVE_FRAMES_RST = 5'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PAGE_BYTES    = 2'd0,
    CFG_ACTIVE_FRAMES = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } st_e;

  // one frame table entry: resident page and recency rank (0 = most recent)
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [RANK_BITS-1:0] rank;
  } entry_t;

endpackage

// ===== sv/lpr_req_if.sv =====
// request channel carrying one address item
interface lpr_req_if #(
  parameter int ADDR_BITS = lpr_pkg::ADDR_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// ===== sv/lpr_rsp_if.sv =====
// result channel carrying hit, frame, page and fault count
interface lpr_rsp_if ();
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [lpr_pkg::FRAME_OUT_BITS-1:0]  frame_index;
  logic [lpr_pkg::PAGE_BITS-1:0]       page_number;
  logic [lpr_pkg::FAULT_BITS-1:0]      fault_total;

  modport source (output valid, output hit, output frame_index, output page_number,
                  output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input page_number,
                  input fault_total, output ready);
endinterface

// ===== sv/lpr_divider.sv =====
// restoring divider, one quotient bit per cycle
module lpr_divider #(
  parameter int DVD_BITS = lpr_pkg::ADDR_BITS_DEF,
  parameter int DVS_BITS = lpr_pkg::PAGE_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_BITS-1:0] dividend_i,
  input  logic [DVS_BITS-1:0] divisor_i,
  output logic                done_o,
  output logic [DVD_BITS-1:0] quotient_o
);
  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic                busy_q;
  logic                done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [DVD_BITS-1:0] dvd_q;
  logic [DVS_BITS-1:0] rem_q;
  logic [DVS_BITS-1:0] divisor_q;

  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   rem_diff;
  logic                ge;

  // a zero divisor makes every step succeed, giving an all-ones quotient
  assign rem_sh   = {rem_q, dvd_q[DVD_BITS-1]};
  assign ge       = rem_sh >= {1'b0, divisor_q};
  assign rem_diff = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(DVD_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_BITS-2:0], ge};
      rem_q <= ge ? rem_diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

// ===== sv/lpr_frame_ram.sv =====
// frame table memory, one write and one registered read port
module lpr_frame_ram #(
  parameter int DEPTH = lpr_pkg::MAX_FRAMES_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [IW-1:0]    raddr_i,
  output lpr_pkg::entry_t  rdata_o,
  input  logic             we_i,
  input  logic [IW-1:0]    waddr_i,
  input  lpr_pkg::entry_t  wdata_i
);
  lpr_pkg::entry_t mem_q [DEPTH];
  lpr_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/lru_page_replacement.sv =====
// top level of the lru page replacement block
//
// usage: each item on req_i carries an address; the block divides it by the
// page_bytes register, looks the page up in the first active_frames frames and
// answers with one item on rsp_o: hit flag, frame used, page number and the
// saturating fault count after this request. items are handled one at a time.
// the iterative divider runs while the controller waits on its done flag, a
// pass scans the frame memory and a second pass rewrites the recency ranks
// (one memory entry per cycle, over the frames in use); a hand-off step then
// loads the output register. a new item is taken as soon as the previous one
// has reached the output register, even while that result still waits on
// rsp_o.ready; a stalled receiver only blocks the hand-off of the next result.
// reset empties all frames (valid flip-flops) and clears the fault count and
// the registers to their defaults; page and rank memory contents need no
// clearing since an empty frame is never read for its contents.
// configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, as the block itself does not enforce this.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
  parameter int ADDR_BITS  = lpr_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [lpr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  lpr_req_if.sink                            req_i,
  lpr_rsp_if.source                          rsp_o
);
  // frame index width and a count width that can hold MAX_FRAMES itself
  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int PW = lpr_pkg::PAGE_BITS;
  localparam int RW = lpr_pkg::RANK_BITS;
  localparam int FW = lpr_pkg::FRAME_OUT_BITS;

  lpr_pkg::st_e state_q, state_d;

  // configuration registers
  logic [PW-1:0]                   page_bytes_q;
  logic [lpr_pkg::ACTIVE_BITS-1:0] active_frames_q;
  logic [CW-1:0]                   n_frames;

  // sequencing
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] e_idx;
  logic          have_data;
  logic          last;
  logic          accept;

  // divider
  logic                 div_done;
  logic [ADDR_BITS-1:0] quotient;
  logic [PW+ADDR_BITS-1:0] quot_ext;
  logic [PW-1:0]        page_calc;
  logic [PW-1:0]        pg_q;

  // frame state
  logic [MAX_FRAMES-1:0] valid_q;
  logic                  ent_valid;
  lpr_pkg::entry_t       ram_rdata;
  lpr_pkg::entry_t       ram_wdata;
  logic                  ram_we;
  logic [IW-1:0]         ram_raddr;

  // scan results
  logic          hit_found_q;
  logic [IW-1:0] hit_idx_q;
  logic [RW-1:0] hit_rank_q;
  logic          empty_found_q;
  logic [IW-1:0] empty_idx_q;
  logic [IW-1:0] best_idx_q;
  logic [RW-1:0] best_rank_q;
  logic [IW-1:0] tgt_idx;
  logic          is_fault;

  // fault counter and output register
  logic [lpr_pkg::FAULT_BITS-1:0] fault_q;
  logic [lpr_pkg::FAULT_BITS-1:0] fault_next;
  logic [FW+IW-1:0]               tgt_ext;
  logic                           out_load;
  logic                           out_valid_q;
  logic                           out_hit_q;
  logic [FW-1:0]                  out_frame_q;
  logic [PW-1:0]                  out_page_q;
  logic [lpr_pkg::FAULT_BITS-1:0] out_fault_q;

  // out-of-range frame counts are pulled into 1..MAX_FRAMES
  always_comb begin
    if (active_frames_q == '0) begin
      n_frames = CW'(1);
    end else if (int'(active_frames_q) > MAX_FRAMES) begin
      n_frames = CW'(MAX_FRAMES);
    end else begin
      n_frames = CW'(active_frames_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q    <= lpr_pkg::PAGE_BYTES_RST;
      active_frames_q <= lpr_pkg::ACTIVE_FRAMES_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lpr_pkg::CFG_PAGE_BYTES) begin
        page_bytes_q <= cfg_data_i[PW-1:0];
      end else if (cfg_idx_i == lpr_pkg::CFG_ACTIVE_FRAMES) begin
        active_frames_q <= cfg_data_i[lpr_pkg::ACTIVE_BITS-1:0];
      end
    end
  end

  assign accept = req_i.valid && req_i.ready;

  lpr_divider #(
    .DVD_BITS (ADDR_BITS),
    .DVS_BITS (PW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (req_i.address),
    .divisor_i  (page_bytes_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // quotient truncated to the page width; zero page size reads as all ones
  assign quot_ext  = {{PW{1'b0}}, quotient};
  assign page_calc = (page_bytes_q == '0) ? {PW{1'b1}} : quot_ext[PW-1:0];

  // both memory passes read entry cnt while entry cnt-1 comes back
  assign have_data = cnt_q != '0;
  assign last      = cnt_q == n_frames;
  assign e_idx     = IW'(cnt_q - CW'(1));
  assign ram_raddr = last ? '0 : cnt_q[IW-1:0];
  assign ent_valid = valid_q[e_idx];

  lpr_frame_ram #(
    .DEPTH (MAX_FRAMES),
    .IW    (IW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (e_idx),
    .wdata_i (ram_wdata)
  );

  // hit frame, else first empty frame, else highest rank
  assign is_fault = !hit_found_q;
  assign tgt_idx  = hit_found_q ? hit_idx_q : (empty_found_q ? empty_idx_q : best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpr_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = ram_rdata;
    unique case (state_q)
      lpr_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = lpr_pkg::ST_DIV;
        end
      end
      lpr_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lpr_pkg::ST_SCAN;
          cnt_d   = '0;
        end
      end
      lpr_pkg::ST_SCAN: begin
        if (last) begin
          state_d = lpr_pkg::ST_UPDATE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      lpr_pkg::ST_UPDATE: begin
        if (have_data) begin
          if (e_idx == tgt_idx) begin
            // frame used becomes most recent
            ram_we    = 1'b1;
            ram_wdata = '{page: pg_q, rank: '0};
          end else if (ent_valid && (is_fault || ram_rdata.rank < hit_rank_q) &&
                       ram_rdata.rank != lpr_pkg::RANK_MAX) begin
            ram_we    = 1'b1;
            ram_wdata = '{page: ram_rdata.page, rank: ram_rdata.rank + RW'(1)};
          end
        end
        if (last) begin
          state_d = lpr_pkg::ST_FINISH;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      lpr_pkg::ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpr_pkg::ST_DIV && div_done) begin
      pg_q <= page_calc;
    end
  end

  // scan pass: first hit, first empty frame, lowest-index highest rank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
    end else if (state_q == lpr_pkg::ST_DIV) begin
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
    end else if (state_q == lpr_pkg::ST_SCAN && have_data) begin
      if (ent_valid && ram_rdata.page == pg_q && !hit_found_q) begin
        hit_found_q <= 1'b1;
      end
      if (!ent_valid && !empty_found_q) begin
        empty_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpr_pkg::ST_SCAN && have_data) begin
      if (ent_valid && ram_rdata.page == pg_q && !hit_found_q) begin
        hit_idx_q  <= e_idx;
        hit_rank_q <= ram_rdata.rank;
      end
      if (!ent_valid && !empty_found_q) begin
        empty_idx_q <= e_idx;
      end
      if (cnt_q == CW'(1) || (ent_valid && ram_rdata.rank > best_rank_q)) begin
        best_idx_q  <= e_idx;
        best_rank_q <= ram_rdata.rank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (state_q == lpr_pkg::ST_UPDATE && have_data && e_idx == tgt_idx) begin
      valid_q[e_idx] <= 1'b1;
    end
  end

  assign fault_next = (is_fault && fault_q != '1) ? fault_q + 1'b1 : fault_q;
  assign tgt_ext    = {{FW{1'b0}}, tgt_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      fault_q     <= fault_next;
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q   <= hit_found_q;
      out_frame_q <= tgt_ext[FW-1:0];
      out_page_q  <= pg_q;
      out_fault_q <= fault_next;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.frame_index = out_frame_q;
  assign rsp_o.page_number = out_page_q;
  assign rsp_o.fault_total = out_fault_q;

`ifndef SYNTH
  // a filled frame never empties again
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & $past(valid_q)) == $past(valid_q))
    else $error("frame valid bit cleared");

  // outside the last step, the rank rewrite never writes the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (e_idx != ram_raddr || last))
    else $error("frame memory read and write collide");

  // a result only appears after the hand-off cycle
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lpr_pkg::ST_FINISH))
    else $error("result loaded outside hand-off");

  // the fault count never goes down
  a_fault_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q >= $past(fault_q))
    else $error("fault count decreased");
`endif
endmodule
